[hw/rtl/acrms_pkg.sv]
// Shared types and constants for the two-channel RMS meter.
package acrms_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned CountW  = 13;
  localparam int unsigned OffW    = 20;
  localparam int unsigned WordW   = 32;
  localparam int unsigned AlphaW  = 17;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegCurGain   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVolGain   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCurFloor  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegVolFloor  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOffAlpha  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSmAlpha   = 3'd5;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_SCALE,
    ST_EMA,
    ST_NEXT,
    ST_OUT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic accumulate;
    logic latch_window;
    logic start_prep;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic scale_step;
    logic ema_step;
    logic next_chan;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic short_win;
    logic step_done;
    logic chan_last;
    logic out_busy;
  } dp_sts_t;

endpackage

[hw/rtl/acrms_ctrl.sv]
// Controller state machine for the RMS meter.
module acrms_ctrl
  import acrms_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_window_end_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC:   if (in_valid_i && in_window_end_i) state_d = ST_PREP;
      ST_PREP:  state_d = sts_i.short_win ? ST_ACC : ST_MUL;
      ST_MUL:   if (sts_i.step_done) state_d = ST_DIV;
      ST_DIV:   if (sts_i.step_done) state_d = ST_SQRT;
      ST_SQRT:  if (sts_i.step_done) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_EMA;
      ST_EMA:   state_d = sts_i.chan_last ? ST_OUT : ST_NEXT;
      ST_NEXT:  state_d = ST_MUL;
      ST_OUT:   if (!sts_i.out_busy) state_d = ST_ACC;
      default:  state_d = ST_ACC;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_ACC: begin
        in_stall_o        = 1'b0;
        cmd_o.accumulate  = in_valid_i;
        cmd_o.latch_window = in_valid_i && in_window_end_i;
      end
      ST_PREP:  cmd_o.start_prep = 1'b1;
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.div_init = sts_i.step_done;
      end
      ST_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.sqrt_init = sts_i.step_done;
      end
      ST_SQRT:  cmd_o.sqrt_step = 1'b1;
      ST_SCALE: cmd_o.scale_step = 1'b1;
      ST_EMA:   cmd_o.ema_step = 1'b1;
      ST_NEXT:  cmd_o.next_chan = 1'b1;
      ST_OUT:   cmd_o.out_load = !sts_i.out_busy;
      default:  cmd_o = '0;
    endcase
  end

endmodule

[hw/rtl/acrms_dp.sv]
// Datapath: window accumulators, mul/div/sqrt sequencing, EMA state, result register.
module acrms_dp
  import acrms_pkg::*;
#(
  parameter int unsigned MaxSamples = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WordW-1:0]    cfg_data_i,
  input  logic [SampleW-1:0]  current_mv_i,
  input  logic [SampleW-1:0]  voltage_mv_i,
  input  logic                pair_valid_i,
  input  logic [SampleW-1:0]  battery_mv_i,
  input  logic                battery_valid_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WordW-1:0]    current_smoothed_o,
  output logic [WordW-1:0]    voltage_smoothed_o,
  output logic [SampleW-1:0]  battery_avg_mv_o,
  output logic [OffW-1:0]     current_offset_o,
  output logic [OffW-1:0]     voltage_offset_o,
  output logic [CountW-1:0]   sample_total_o
);

  localparam int unsigned NW   = $clog2(MaxSamples + 1);
  localparam int unsigned SW   = SampleW + NW;
  localparam int unsigned QW   = 2 * SampleW + NW;
  localparam int unsigned DW   = 2 * SW;      // n*sumsq width
  localparam int unsigned N2W  = 2 * NW;
  localparam int unsigned VW   = 2 * SampleW + 16; // var_q16 bits
  localparam int unsigned RW   = VW / 2 + 1;
  localparam int unsigned DNW  = DW + 16;     // dividend width for var
  localparam int unsigned DCNT = $clog2(DNW + 1);
  localparam int unsigned SCNT = $clog2(RW + 1);
  localparam int unsigned MBIT = $clog2(SW + 1);
  localparam logic [NW-1:0] MaxN = NW'(MaxSamples);

  // configuration
  logic [WordW-1:0]  cgain_q, vgain_q, cfloor_q, vfloor_q;
  logic [AlphaW-1:0] oalpha_q, salpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cgain_q  <= '0;
      vgain_q  <= '0;
      cfloor_q <= '0;
      vfloor_q <= '0;
      oalpha_q <= '0;
      salpha_q <= AlphaW'(17'h10000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCurGain:  cgain_q  <= cfg_data_i;
        RegVolGain:  vgain_q  <= cfg_data_i;
        RegCurFloor: cfloor_q <= cfg_data_i;
        RegVolFloor: vfloor_q <= cfg_data_i;
        RegOffAlpha: oalpha_q <= cfg_data_i[AlphaW-1:0];
        RegSmAlpha:  salpha_q <= cfg_data_i[AlphaW-1:0];
        default: ;
      endcase
    end
  end

  // window accumulators
  logic [NW-1:0] pcnt_q, bcnt_q;
  logic [SW-1:0] csum_q, vsum_q, bsum_q;
  logic [QW-1:0] csq_q, vsq_q;
  logic [NW-1:0] pcnt_a;
  logic [SW-1:0] csum_a, vsum_a, bsum_a;
  logic [QW-1:0] csq_a, vsq_a;
  logic [NW-1:0] bcnt_a;

  always_comb begin
    pcnt_a = pcnt_q;
    csum_a = csum_q;
    vsum_a = vsum_q;
    csq_a  = csq_q;
    vsq_a  = vsq_q;
    bcnt_a = bcnt_q;
    bsum_a = bsum_q;
    if (pair_valid_i && pcnt_q < MaxN) begin
      pcnt_a = pcnt_q + NW'(1);
      csum_a = csum_q + SW'(current_mv_i);
      vsum_a = vsum_q + SW'(voltage_mv_i);
      csq_a  = csq_q + QW'(current_mv_i) * QW'(current_mv_i);
      vsq_a  = vsq_q + QW'(voltage_mv_i) * QW'(voltage_mv_i);
    end
    if (battery_valid_i && bcnt_q < MaxN) begin
      bcnt_a = bcnt_q + NW'(1);
      bsum_a = bsum_q + SW'(battery_mv_i);
    end
  end

  // latched window
  logic [NW-1:0] n_q, bn_q;
  logic [SW-1:0] wcs_q, wvs_q, wbs_q;
  logic [QW-1:0] wcq_q, wvq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0;
      bcnt_q <= '0;
      csum_q <= '0;
      vsum_q <= '0;
      bsum_q <= '0;
      csq_q  <= '0;
      vsq_q  <= '0;
    end else if (cmd_i.latch_window) begin
      pcnt_q <= '0;
      bcnt_q <= '0;
      csum_q <= '0;
      vsum_q <= '0;
      bsum_q <= '0;
      csq_q  <= '0;
      vsq_q  <= '0;
    end else if (cmd_i.accumulate) begin
      pcnt_q <= pcnt_a;
      bcnt_q <= bcnt_a;
      csum_q <= csum_a;
      vsum_q <= vsum_a;
      bsum_q <= bsum_a;
      csq_q  <= csq_a;
      vsq_q  <= vsq_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_window) begin
      n_q   <= pcnt_a;
      bn_q  <= bcnt_a;
      wcs_q <= csum_a;
      wvs_q <= vsum_a;
      wbs_q <= bsum_a;
      wcq_q <= csq_a;
      wvq_q <= vsq_a;
    end
  end

  // channel select: 0 current, 1 voltage
  logic chan_q;
  logic [SW-1:0] sum_sel;
  logic [QW-1:0] sq_sel;
  assign sum_sel = chan_q ? wvs_q : wcs_q;
  assign sq_sel  = chan_q ? wvq_q : wcq_q;

  // shift-add multiplier: n*sumsq and sum^2 (n*n direct, sum*256/n via divider)
  logic [MBIT-1:0] mcnt_q;
  logic [DW-1:0]   acc_nsq_q, acc_ss_q;
  logic [DW-1:0]   acc_nsq_d, acc_ss_d;
  logic [N2W-1:0]  n2_q;
  logic            mul_done;
  assign mul_done = (mcnt_q == MBIT'(SW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
      chan_q <= 1'b0;
    end else begin
      if (cmd_i.start_prep) chan_q <= 1'b0;
      else if (cmd_i.next_chan) chan_q <= 1'b1;
      if (cmd_i.mul_step) mcnt_q <= mul_done ? '0 : mcnt_q + MBIT'(1);
    end
  end

  // one partial product per cycle: bit mcnt of sum and of n
  always_comb begin
    acc_nsq_d = acc_nsq_q;
    acc_ss_d  = acc_ss_q;
    if (mcnt_q < MBIT'(NW) && n_q[mcnt_q[$clog2(NW)-1:0]])
      acc_nsq_d = acc_nsq_q + (DW'(sq_sel) << mcnt_q);
    if (sum_sel[mcnt_q[$clog2(SW)-1:0]])
      acc_ss_d = acc_ss_q + (DW'(sum_sel) << mcnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_prep || cmd_i.next_chan) begin
      acc_nsq_q <= '0;
      acc_ss_q  <= '0;
      n2_q      <= N2W'(n_q) * N2W'(n_q);
    end else if (cmd_i.mul_step) begin
      acc_nsq_q <= acc_nsq_d;
      acc_ss_q  <= acc_ss_d;
    end
  end

  // restoring divider: var = ((d<<16) / n2), mean = (sum<<8)/n in parallel
  logic [DCNT-1:0] dcnt_q;
  logic [DNW-1:0]  dquo_q;
  logic [N2W:0]    drem_q;
  logic [SW+8-1:0] mquo_q;
  logic [NW:0]     mrem_q;
  logic            div_done;
  logic [N2W:0]    drem_sh;
  logic [NW:0]     mrem_sh;
  logic [DNW-1:0]  dvd;
  logic [SW+8-1:0] mdvd;
  logic [DNW-1:0]  dquo_d;
  assign div_done = (dcnt_q == DCNT'(DNW - 1));
  // the last partial product lands on the edge that starts the divider
  assign dvd  = {acc_nsq_d - acc_ss_d, 16'd0};
  assign mdvd = {sum_sel, 8'd0};

  always_comb begin
    drem_sh = {drem_q[N2W-1:0], dquo_q[DNW-1]};
    mrem_sh = {mrem_q[NW-1:0], (dcnt_q >= DCNT'(DNW - SW - 8)) ?
               mquo_q[SW+8-1] : 1'b0};
  end

  // quotient after the current step, so the root starts from the full result
  assign dquo_d = {dquo_q[DNW-2:0], (drem_sh >= (N2W+1)'(n2_q))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= div_done ? '0 : dcnt_q + DCNT'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dquo_q <= dvd;
      drem_q <= '0;
      mquo_q <= mdvd;
      mrem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (drem_sh >= (N2W+1)'(n2_q)) begin
        drem_q <= drem_sh - (N2W+1)'(n2_q);
        dquo_q <= {dquo_q[DNW-2:0], 1'b1};
      end else begin
        drem_q <= drem_sh;
        dquo_q <= {dquo_q[DNW-2:0], 1'b0};
      end
      // mean divider runs its last SW+8 steps
      if (dcnt_q >= DCNT'(DNW - SW - 8)) begin
        if (mrem_sh >= (NW+1)'(n_q)) begin
          mrem_q <= mrem_sh - (NW+1)'(n_q);
          mquo_q <= {mquo_q[SW+8-2:0], 1'b1};
        end else begin
          mrem_q <= mrem_sh;
          mquo_q <= {mquo_q[SW+8-2:0], 1'b0};
        end
      end
    end
  end

  // digit-by-digit square root, two radicand bits a step
  logic [SCNT-1:0] scnt_q;
  logic [2*RW-1:0] srad_q;
  logic [RW+1:0]   srem_q;
  logic [RW-1:0]   sroot_q;
  logic [RW+1:0]   strial, srem_sh;
  logic            sqrt_done;
  assign sqrt_done = (scnt_q == SCNT'(RW - 1));
  assign srem_sh = {srem_q[RW-1:0], srad_q[2*RW-1 -: 2]};
  assign strial  = {sroot_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      scnt_q <= sqrt_done ? '0 : scnt_q + SCNT'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      srad_q  <= (2*RW)'(dquo_d[VW-1:0]);
      srem_q  <= '0;
      sroot_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      srad_q <= srad_q << 2;
      if (srem_sh >= strial) begin
        srem_q  <= srem_sh - strial;
        sroot_q <= {sroot_q[RW-2:0], 1'b1};
      end else begin
        srem_q  <= srem_sh;
        sroot_q <= {sroot_q[RW-2:0], 1'b0};
      end
    end
  end

  // scale by gain, noise floor; the shifted product never exceeds a word
  logic [WordW-1:0] gain_sel, floor_sel;
  logic [RW+WordW-1:0] prod;
  logic [RW+WordW-25:0] shp;
  logic [WordW-1:0] scaled_q;
  logic [WordW-1:0] sat;
  assign gain_sel  = chan_q ? vgain_q : cgain_q;
  assign floor_sel = chan_q ? vfloor_q : cfloor_q;
  assign prod = (RW+WordW)'(sroot_q) * (RW+WordW)'(gain_sel);
  assign shp  = prod[RW+WordW-1:24];
  assign sat  = WordW'(shp);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_step) scaled_q <= (sat < floor_sel) ? '0 : sat;
  end

  // EMA updates
  logic [AlphaW-1:0] a_cl, s_cl, a_inv, s_inv;
  assign a_cl  = (oalpha_q > AlphaW'(17'h10000)) ? AlphaW'(17'h10000) : oalpha_q;
  assign s_cl  = (salpha_q > AlphaW'(17'h10000)) ? AlphaW'(17'h10000) : salpha_q;
  assign a_inv = AlphaW'(17'h10000) - a_cl;
  assign s_inv = AlphaW'(17'h10000) - s_cl;

  logic [WordW-1:0] cema_q, vema_q;
  logic [OffW-1:0]  cdc_q, vdc_q;
  logic [WordW-1:0] ema_sel;
  logic [OffW-1:0]  dc_sel;
  logic [WordW+AlphaW:0] ema_mix;
  logic [SW+8+AlphaW:0]  dc_mix;
  logic [WordW-1:0] ema_new;
  logic [OffW-1:0]  dc_new;
  assign ema_sel = chan_q ? vema_q : cema_q;
  assign dc_sel  = chan_q ? vdc_q : cdc_q;
  assign ema_mix = (WordW+AlphaW+1)'(s_cl) * (WordW+AlphaW+1)'(scaled_q)
                 + (WordW+AlphaW+1)'(s_inv) * (WordW+AlphaW+1)'(ema_sel);
  assign dc_mix  = (SW+8+AlphaW+1)'(a_cl) * (SW+8+AlphaW+1)'(mquo_q)
                 + (SW+8+AlphaW+1)'(a_inv) * (SW+8+AlphaW+1)'(dc_sel);
  assign ema_new = (|ema_mix[WordW+AlphaW:WordW+16]) ? '1 : ema_mix[WordW+15:16];
  assign dc_new  = dc_mix[OffW+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cema_q <= '0;
      vema_q <= '0;
      cdc_q  <= '0;
      vdc_q  <= '0;
    end else if (cmd_i.ema_step) begin
      if (chan_q) begin
        vema_q <= ema_new;
        vdc_q  <= dc_new;
      end else begin
        cema_q <= ema_new;
        cdc_q  <= dc_new;
      end
    end
  end

  // battery mean: small serial divider run during the channel work
  logic [SW-1:0]   bquo_q;
  logic [NW:0]     brem_q;
  logic [NW:0]     brem_sh;
  assign brem_sh = {brem_q[NW-1:0], bquo_q[SW-1]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_prep) begin
      bquo_q <= wbs_q;
      brem_q <= '0;
    end else if (cmd_i.mul_step && !chan_q) begin
      if (brem_sh >= (NW+1)'(bn_q) && bn_q != '0) begin
        brem_q <= brem_sh - (NW+1)'(bn_q);
        bquo_q <= {bquo_q[SW-2:0], 1'b1};
      end else begin
        brem_q <= brem_sh;
        bquo_q <= {bquo_q[SW-2:0], 1'b0};
      end
    end
  end

  // output register
  logic ovalid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      current_smoothed_o <= cema_q;
      voltage_smoothed_o <= vema_q;
      battery_avg_mv_o   <= bquo_q[SampleW-1:0];
      current_offset_o   <= cdc_q;
      voltage_offset_o   <= vdc_q;
      sample_total_o     <= CountW'(n_q);
    end
  end

  assign out_valid_o     = ovalid_q;
  assign sts_o.short_win = (n_q < NW'(2));
  assign sts_o.step_done = cmd_i.mul_step ? mul_done :
                           cmd_i.div_step ? div_done : sqrt_done;
  assign sts_o.chan_last = chan_q;
  assign sts_o.out_busy  = ovalid_q && out_stall_i;

endmodule

[hw/rtl/ac_rms_meter_two_channel_core.sv]
// Top level of the two-channel windowed true-RMS meter.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one sample word per cycle
//   while accumulating. A word with window_end set closes the window; the
//   block then stalls input while it evaluates both channels.
//   Output channel (out_valid_o / out_stall_i) gives one result word per
//   window with at least two valid pairs; shorter windows give nothing.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are taken every cycle.
// Evaluation:
//   Accumulation runs at one word per cycle. After a window end the input
//   stalls; a short window goes straight back to accumulating, else both
//   channels are evaluated in turn by the serial shift-add multiplier, the
//   restoring divider (one quotient bit per cycle) and the square-root unit
//   (one root bit per cycle), which they share. The result word shows at the
//   edge that reopens the input.
// Reset clears the accumulators, EMA and offset state and the output valid flag.
// A stalled result holds on the output register; the block waits for it to
// be taken before reopening the input.
module ac_rms_meter_two_channel_core
  import acrms_pkg::*;
#(
  parameter int unsigned MaxSamples = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  current_mv_i,
  input  logic [SampleW-1:0]  voltage_mv_i,
  input  logic                pair_valid_i,
  input  logic [SampleW-1:0]  battery_mv_i,
  input  logic                battery_valid_i,
  input  logic                window_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WordW-1:0]    current_smoothed_o,
  output logic [WordW-1:0]    voltage_smoothed_o,
  output logic [SampleW-1:0]  battery_avg_mv_o,
  output logic [OffW-1:0]     current_offset_o,
  output logic [OffW-1:0]     voltage_offset_o,
  output logic [CountW-1:0]   sample_total_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [WordW-1:0]    cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  acrms_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_window_end_i (window_end_i),
    .in_stall_o      (in_stall_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  acrms_dp #(.MaxSamples(MaxSamples)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_valid_i),
    .cfg_idx_i          (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .current_mv_i       (current_mv_i),
    .voltage_mv_i       (voltage_mv_i),
    .pair_valid_i       (pair_valid_i),
    .battery_mv_i       (battery_mv_i),
    .battery_valid_i    (battery_valid_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .current_smoothed_o (current_smoothed_o),
    .voltage_smoothed_o (voltage_smoothed_o),
    .battery_avg_mv_o   (battery_avg_mv_o),
    .current_offset_o   (current_offset_o),
    .voltage_offset_o   (voltage_offset_o),
    .sample_total_o     (sample_total_o)
  );

endmodule

[hw/rtl/acrms_checker.sv]
// Port-level checker for the RMS meter, bound to the top level.
module acrms_checker
  import acrms_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               window_end_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [CountW-1:0]  sample_total_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_total_o))
    else $error("stalled result changed");

  // a window end closes the input for evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && window_end_i |=> in_stall_o)
    else $error("input open after window end");

  // every result covers at least two pairs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_total_o >= CountW'(2))
    else $error("result from short window");

  // a new result appears only while input is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result while accumulating");

endmodule

bind ac_rms_meter_two_channel_core acrms_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .window_end_i   (window_end_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sample_total_o (sample_total_o)
);
